@@ sv/bpmmu_pkg.sv @@
// Shared types and constants for the banked page MMU translator.
// Has no dependencies; imported by banked_page_mmu_translate.
package bpmmu_pkg;

   typedef logic [1:0]  size_mode_type;
   typedef logic [9:0]  page_reg_type;
   typedef logic [10:0] page_type;
   typedef logic [2:0]  op_type;

   localparam op_type OP_ACCESS     = 3'd0;
   localparam op_type OP_PAGE_WRITE = 3'd1;
   localparam op_type OP_MMU_ENABLE = 3'd2;
   localparam op_type OP_TASK       = 3'd3;
   localparam op_type OP_ROM_MAP    = 3'd4;
   localparam op_type OP_MAP_TYPE   = 3'd5;
   localparam op_type OP_VECTORS    = 3'd6;
   localparam op_type OP_EXT_BANK   = 3'd7;

   localparam size_mode_type SIZE_MODE_RESET = 2'd1;
   localparam size_mode_type SIZE_MODE_2048K = 2'd2;
   localparam size_mode_type SIZE_MODE_8192K = 2'd3;

   localparam logic [1:0] ROM_MAP_INTERNAL = 2'd2;
   localparam logic [1:0] ROM_MAP_EXTERNAL = 2'd3;

   localparam logic [15:0] VEC_LOW     = 16'hFE00;
   localparam logic [15:0] VEC_HIGH    = 16'hFEFF;
   localparam logic [12:0] OFFSET_MASK = 13'h1FFF;
   localparam logic [7:0]  PREFIX_FIELD = 8'h30;

   localparam logic [2:0] ROM_FIRST_SLOT = 3'd4;
   localparam logic [2:0] EXT_FIRST_SLOT = 3'd6;

   // RAM page mask for each size mode.
   function automatic page_reg_type ram_mask(input size_mode_type mode);
      page_reg_type res;
      case (mode)
         2'd0:    res = 10'd15;
         2'd1:    res = 10'd63;
         2'd2:    res = 10'd255;
         default: res = 10'd1023;
      endcase
      return res;
   endfunction

   // First default page used while the MMU is off.
   function automatic page_reg_type default_base(input size_mode_type mode);
      page_reg_type res;
      case (mode)
         2'd0:    res = 10'd8;
         default: res = 10'd56;
      endcase
      return res;
   endfunction

   // Page that the vector window maps to.
   function automatic page_reg_type vector_page(input size_mode_type mode);
      page_reg_type res;
      case (mode)
         2'd0:    res = 10'd15;
         default: res = 10'd63;
      endcase
      return res;
   endfunction

endpackage

@@ sv/banked_page_mmu_translate.sv @@
// Banked page MMU translator: CPU address to 8 KB page physical address.
// Depends on bpmmu_pkg for opcodes, size tables and types.
//
// An accepted access is registered in stage 1, then in the output register.
// Throughput: one transaction per cycle unless stalled, set by the page memory's one read port.
// Reset (synchronous, active high) clears control flags and the valid bits of the page memory;
// no clearing pass is needed, a never-written page register reads as its reset default.
module banked_page_mmu_translate
   import bpmmu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_cpu_address,
   input  logic [3:0]  req_reg_index,
   input  logic [7:0]  req_write_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_physical_address,
   output logic        rsp_target,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_ram_size_mode
);

   // Control state. These registers are written when the operation that
   // changes them is accepted, so an access that follows in the next cycle
   // already sees the new value.
   size_mode_type size_mode_ff;
   logic          task_ff;
   logic          mmu_on_ff;
   logic          vectors_on_ff;
   logic [1:0]    rom_map_ff;
   logic          all_ram_ff;
   logic [1:0]    prefix_ff;

   // Page register store: a 16-entry synchronous memory with one read and
   // one write port. Each entry has a valid bit so that reset needs no sweep.
   page_reg_type  page_mem [16];
   logic [15:0]   entry_valid_ff;

   // Stage 1: access transaction waiting on the memory read data.
   logic          s1_valid_ff;
   logic [15:0]   s1_addr_ff;
   page_reg_type  s1_rd_ff;
   logic          s1_hit_ff;

   // Output register.
   logic          rsp_valid_ff;
   logic [23:0]   rsp_addr_ff;
   logic          rsp_target_ff;

   logic          s1_advance;
   logic          req_accept;
   logic          is_access;
   logic [3:0]    rd_index;
   page_reg_type  mask_cur;
   page_reg_type  base_cur;
   page_reg_type  reg_page;
   page_type      slot_pg;
   page_type      final_pg;
   logic [2:0]    s1_slot;
   logic [23:0]   rsp_addr_in;
   logic          rsp_target_in;

   // Stage 1 moves on when the output register is empty or being drained.
   // A non-access operation completes at acceptance, yet it is held off too
   // while stage 1 is stuck so the flags stay fixed under a waiting access.
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign is_access  = (req_operation == OP_ACCESS);
   assign csr_ready  = 1'b1;

   assign mask_cur = ram_mask(size_mode_ff);
   assign base_cur = default_base(size_mode_ff);
   assign rd_index = {task_ff, req_cpu_address[15:13]};

   // Control register updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_mode_ff   <= SIZE_MODE_RESET;
         task_ff        <= 1'b0;
         mmu_on_ff      <= 1'b0;
         vectors_on_ff  <= 1'b0;
         rom_map_ff     <= 2'd0;
         all_ram_ff     <= 1'b0;
         prefix_ff      <= 2'd0;
         entry_valid_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_mode_ff <= csr_ram_size_mode;
         end
         if (req_accept) begin
            case (req_operation)
               OP_PAGE_WRITE: begin
                  entry_valid_ff[req_reg_index] <= 1'b1;
               end
               OP_MMU_ENABLE: mmu_on_ff     <= (req_write_data != 8'd0);
               OP_TASK:       task_ff       <= req_write_data[0];
               OP_ROM_MAP:    rom_map_ff    <= req_write_data[1:0];
               OP_MAP_TYPE:   all_ram_ff    <= (req_write_data != 8'd0);
               OP_VECTORS:    vectors_on_ff <= (req_write_data != 8'd0);
               OP_EXT_BANK: begin
                  if (size_mode_ff == SIZE_MODE_2048K) begin
                     prefix_ff <= 2'd0;
                  end else if (size_mode_ff == SIZE_MODE_8192K) begin
                     prefix_ff <= 2'((req_write_data & PREFIX_FIELD) >> 4);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Page memory: the write takes the bank prefix and the data masked to
   // the RAM size. Reads and writes come from different transactions, so
   // they never meet at one edge and no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_accept && (req_operation == OP_PAGE_WRITE)) begin
         page_mem[req_reg_index] <= {prefix_ff, req_write_data & mask_cur[7:0]};
      end
      if (req_accept && is_access) begin
         s1_rd_ff  <= page_mem[rd_index];
         s1_hit_ff <= entry_valid_ff[rd_index];
         s1_addr_ff <= req_cpu_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= is_access;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Stage 2: choose the page for the slot and form the physical address.
   assign s1_slot  = s1_addr_ff[15:13];
   // A never-written register holds its reset default: the base for the
   // reset size mode plus the slot number.
   assign reg_page = s1_hit_ff ? s1_rd_ff
                               : default_base(SIZE_MODE_RESET) + 10'(s1_slot);

   always_comb begin
      if (all_ram_ff || (s1_slot < ROM_FIRST_SLOT)) begin
         if (mmu_on_ff) begin
            slot_pg = page_type'(reg_page);
         end else begin
            slot_pg = page_type'(base_cur) + page_type'(s1_slot);
         end
      end else begin
         case (rom_map_ff)
            ROM_MAP_INTERNAL: slot_pg = page_type'(mask_cur) + page_type'(s1_slot) - 11'd3;
            ROM_MAP_EXTERNAL: slot_pg = page_type'(mask_cur) + page_type'(s1_slot) + 11'd1;
            default: begin
               // Split map: two internal ROM pages, then two external ones.
               if (s1_slot < EXT_FIRST_SLOT) begin
                  slot_pg = page_type'(mask_cur) + page_type'(s1_slot) - 11'd3;
               end else begin
                  slot_pg = page_type'(mask_cur) + page_type'(s1_slot) - 11'd1;
               end
            end
         endcase
      end

      if (vectors_on_ff && (s1_addr_ff >= VEC_LOW)) begin
         final_pg = page_type'(vector_page(size_mode_ff));
      end else begin
         final_pg = slot_pg;
      end

      // Addresses above the vector window go straight to I/O.
      if (s1_addr_ff > VEC_HIGH) begin
         rsp_addr_in   = {8'd0, s1_addr_ff};
         rsp_target_in = 1'b1;
      end else begin
         rsp_addr_in   = {final_pg, s1_addr_ff[12:0] & OFFSET_MASK};
         rsp_target_in = 1'b0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_target_ff <= rsp_target_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_target           = rsp_target_ff;

endmodule
